>>> hdl/rth_pkg.sv
// Package for the ray / triangle hit test: default widths, fixed sizes
// and the outcome codes. No dependencies.
package rth_pkg;

  localparam int COORD_BITS_DEF      = 20;
  localparam int RATIO_FRAC_BITS_DEF = 16;

  // input words carry three packed coordinates
  localparam int WORD_W    = 60;
  // distance ratio width and its split for the hit point multipliers
  localparam int DIST_W    = 64;
  localparam int DIST_HALF = 32;
  localparam int OC_W      = 3;

  typedef enum logic [OC_W-1:0] {
    OC_HIT        = 3'd0,
    OC_DEGEN      = 3'd1,
    OC_NOT_FACING = 3'd2,
    OC_BEHIND     = 3'd3,
    OC_OUTSIDE    = 3'd4
  } outcome_t;

endpackage

>>> hdl/rth_if.sv
// Channel interfaces of the ray / triangle hit test.
// Depends on rth_pkg.
interface rth_in_if;
  import rth_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] vertex_a;
  logic [WORD_W-1:0] vertex_b;
  logic [WORD_W-1:0] vertex_c;
  logic [WORD_W-1:0] ray_origin;
  logic [WORD_W-1:0] ray_toward;
  modport source (output valid, vertex_a, vertex_b, vertex_c, ray_origin, ray_toward,
                  input ready);
  modport sink (input valid, vertex_a, vertex_b, vertex_c, ray_origin, ray_toward,
                output ready);
endinterface

interface rth_out_if #(
  parameter int COORD_BITS = rth_pkg::COORD_BITS_DEF
);
  import rth_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [OC_W-1:0]              outcome;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source (output valid, hit, outcome, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, outcome, point_x, point_y, point_z, output ready);
endinterface

>>> hdl/rth_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; stall-safe valid/ready between stages.
module rth_div #(
  parameter int NUM_W  = 82,
  parameter int DEN_W  = 66,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W:1]   vld;
  logic [NUM_W+1:1] en;
  logic [DEN_W-1:0]  rem [1:NUM_W];
  logic [DEN_W-1:0]  dn  [1:NUM_W];
  logic [NUM_W-1:0]  nq  [1:NUM_W];
  logic [SIDE_W-1:0] sd  [1:NUM_W];

  assign en[NUM_W+1] = out_ready;

  for (genvar i = 1; i <= NUM_W; i++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    logic [NUM_W-1:0]  q_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 1) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign d_in = den;
      assign q_in = num;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign d_in = dn[i-1];
      assign q_in = nq[i-1];
      assign s_in = sd[i-1];
    end

    // remainder stays below the divisor, so the borrow bit is the compare
    assign trial = {r_in, q_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = !diff[DEN_W];
    assign en[i] = !vld[i] || en[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[i]  <= {q_in[NUM_W-2:0], ge};
        dn[i]  <= d_in;
        sd[i]  <= s_in;
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NUM_W];
  assign quo       = nq[NUM_W];
  assign side_out  = sd[NUM_W];

endmodule

>>> hdl/ray_triangle_hit_test.sv
// Stages: 5 of normal and dot products, one divider stage per quotient bit,
//   6 of hit point and edge tests including the output register.
// Throughput: one item per cycle; every stage has its own valid bit, so
//   bubbles close up and a stalled output holds without loss.
// Reset (synchronous, rst high) clears the valid bits only.
module ray_triangle_hit_test #(
  parameter int COORD_BITS      = rth_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = rth_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rth_in_if.sink    in_ch,
  rth_out_if.source out_ch
);
  import rth_pkg::*;

  // widths: coordinate, difference, normal component, dot product
  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int NW  = 2 * DW + 1;
  localparam int DPW = NW + DW + 2;
  // divider numerator is the distance numerator scaled by the ratio fraction
  localparam int QW  = DPW + RATIO_FRAC_BITS;
  localparam int QX  = (QW > DIST_W) ? QW : DIST_W;
  // hit point: v times half a distance, then the whole product
  localparam int LW  = DW + DIST_HALF + 1;
  localparam int PW  = DW + DIST_W + 1;
  localparam int SW  = PW + 1;
  // edge dot: normal split in low (unsigned) and high (signed) halves
  localparam int NLO = (NW + 1) / 2;
  localparam int NHI = NW - NLO;
  localparam int ML  = NW + NLO + 1;
  localparam int MH  = NW + NHI;
  localparam int EW  = 2 * NW + 2;
  localparam longint CMAXV = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint CMINV = -CMAXV - 1;

  typedef logic [2:0][CW-1:0] vc_t;
  typedef logic [2:0][DW-1:0] vd_t;
  typedef logic [2:0][NW-1:0] vn_t;

  typedef struct packed {
    vc_t a, b, c, s;
    vd_t u, w, v, sa;
  } geo_t;

  // what travels alongside the divider
  typedef struct packed {
    vc_t      a, b, c, s;
    vd_t      u, w, v;
    vn_t      n;
    outcome_t oc;   // OC_HIT here means still open
  } side_t;

  typedef struct packed { geo_t g; logic [2:0][1:0][2*DW-1:0] pr; } st2_t;
  typedef struct packed { geo_t g; vn_t n; } st3_t;
  typedef struct packed {
    geo_t                     g;
    vn_t                      n;
    logic [2:0][NW+DW-1:0]    pv;
    logic [2:0][NW+DW-1:0]    ps;
    logic                     deg;
  } st4_t;
  typedef struct packed { side_t sd; logic [DPW-1:0] num, den; } st5_t;

  typedef struct packed { side_t sd; logic [2:0][LW-1:0] pl, ph; } pt1_t;
  typedef struct packed { side_t sd; vc_t p; } pt2_t;
  typedef struct packed {
    side_t                          sd;
    vc_t                            p;
    logic [2:0][2:0][1:0][2*DW-1:0] ep;
  } pt3_t;
  typedef struct packed {
    outcome_t              oc;
    vc_t                   p;
    vn_t                   n;
    logic [2:0][2:0][NW-1:0] t;
  } pt4_t;
  typedef struct packed {
    outcome_t                oc;
    vc_t                     p;
    logic [2:0][2:0][ML-1:0] ml;
    logic [2:0][2:0][MH-1:0] mh;
  } pt5_t;

  localparam int SIDE_W = $bits(side_t);

  function automatic logic [2*DW-1:0] smul(logic [DW-1:0] x, logic [DW-1:0] y);
    return (2*DW)'($signed(x)) * (2*DW)'($signed(y));
  endfunction

  function automatic logic [DW-1:0] cdiff(logic [CW-1:0] x, logic [CW-1:0] y);
    return DW'($signed(x)) - DW'($signed(y));
  endfunction

  // ---------------------------------------------------------------- front end
  logic [5:1] qv;
  logic [5:1] en_q;
  geo_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  st5_t s5, s5_next;

  logic              div_in_ready;
  logic              div_out_valid;
  logic              div_out_ready;
  logic [QW-1:0]     div_quo;
  logic [SIDE_W-1:0] div_side;

  assign en_q[5]     = !qv[5] || div_in_ready;
  assign en_q[4]     = !qv[4] || en_q[5];
  assign en_q[3]     = !qv[3] || en_q[4];
  assign en_q[2]     = !qv[2] || en_q[3];
  assign en_q[1]     = !qv[1] || en_q[2];
  assign in_ch.ready = en_q[1];

  // stage 1: unpack, edge vectors, ray direction, start relative to A
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_next.a[k]  = in_ch.vertex_a[k*CW +: CW];
      s1_next.b[k]  = in_ch.vertex_b[k*CW +: CW];
      s1_next.c[k]  = in_ch.vertex_c[k*CW +: CW];
      s1_next.s[k]  = in_ch.ray_origin[k*CW +: CW];
      s1_next.u[k]  = cdiff(in_ch.vertex_b[k*CW +: CW], in_ch.vertex_a[k*CW +: CW]);
      s1_next.w[k]  = cdiff(in_ch.vertex_c[k*CW +: CW], in_ch.vertex_b[k*CW +: CW]);
      s1_next.v[k]  = cdiff(in_ch.ray_toward[k*CW +: CW], in_ch.ray_origin[k*CW +: CW]);
      s1_next.sa[k] = cdiff(in_ch.ray_origin[k*CW +: CW], in_ch.vertex_a[k*CW +: CW]);
    end
  end

  // stage 2: cross product terms of n = u x w
  always_comb begin
    s2_next.g = s1;
    for (int k = 0; k < 3; k++) begin
      s2_next.pr[k][0] = smul(s1.u[(k+1)%3], s1.w[(k+2)%3]);
      s2_next.pr[k][1] = smul(s1.u[(k+2)%3], s1.w[(k+1)%3]);
    end
  end

  // stage 3: normal
  always_comb begin
    s3_next.g = s2.g;
    for (int k = 0; k < 3; k++) begin
      s3_next.n[k] = NW'($signed(s2.pr[k][0])) - NW'($signed(s2.pr[k][1]));
    end
  end

  // stage 4: dot product terms n.v and n.(S-A)
  always_comb begin
    s4_next.g   = s3.g;
    s4_next.n   = s3.n;
    s4_next.deg = (s3.n == '0);
    for (int k = 0; k < 3; k++) begin
      s4_next.pv[k] = (NW+DW)'($signed(s3.n[k])) * (NW+DW)'($signed(s3.g.v[k]));
      s4_next.ps[k] = (NW+DW)'($signed(s3.n[k])) * (NW+DW)'($signed(s3.g.sa[k]));
    end
  end

  // stage 5: sums and early rejects; divisor and dividend for the distance
  always_comb begin
    logic signed [DPW-1:0] nv;
    logic signed [DPW-1:0] nsa;
    nv  = DPW'($signed(s4.pv[0])) + DPW'($signed(s4.pv[1])) + DPW'($signed(s4.pv[2]));
    nsa = DPW'($signed(s4.ps[0])) + DPW'($signed(s4.ps[1])) + DPW'($signed(s4.ps[2]));
    s5_next.num  = -nsa;
    s5_next.den  = -nv;
    s5_next.sd.a = s4.g.a;
    s5_next.sd.b = s4.g.b;
    s5_next.sd.c = s4.g.c;
    s5_next.sd.s = s4.g.s;
    s5_next.sd.u = s4.g.u;
    s5_next.sd.w = s4.g.w;
    s5_next.sd.v = s4.g.v;
    s5_next.sd.n = s4.n;
    priority if (s4.deg) begin
      s5_next.sd.oc = OC_DEGEN;
    end else if (!nv[DPW-1]) begin
      s5_next.sd.oc = OC_NOT_FACING;
    end else if (nsa > 0) begin
      s5_next.sd.oc = OC_BEHIND;
    end else begin
      s5_next.sd.oc = OC_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
    end else begin
      if (en_q[1]) qv[1] <= in_ch.valid;
      if (en_q[2]) qv[2] <= qv[1];
      if (en_q[3]) qv[3] <= qv[2];
      if (en_q[4]) qv[4] <= qv[3];
      if (en_q[5]) qv[5] <= qv[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en_q[1]) s1 <= s1_next;
    if (en_q[2]) s2 <= s2_next;
    if (en_q[3]) s3 <= s3_next;
    if (en_q[4]) s4 <= s4_next;
    if (en_q[5]) s5 <= s5_next;
  end

  // ------------------------------------------------------------------ divider
  // t = floor(num * 2^RATIO_FRAC_BITS / den), one quotient bit per stage
  rth_div #(
    .NUM_W  (QW),
    .DEN_W  (DPW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qv[5]),
    .in_ready  (div_in_ready),
    .num       ({s5.num, RATIO_FRAC_BITS'(0)}),
    .den       (s5.den),
    .side_in   (s5.sd),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .quo       (div_quo),
    .side_out  (div_side)
  );

  // ----------------------------------------------------------------- back end
  logic [6:1] pv;
  logic [6:1] en_p;
  side_t      dsd;
  logic [QX-1:0]     qx;
  logic [DIST_W-1:0] ratio;
  pt1_t t1, t1_next;
  pt2_t t2, t2_next;
  pt3_t t3, t3_next;
  pt4_t t4, t4_next;
  pt5_t t5, t5_next;
  logic     o_hit, o_hit_next;
  outcome_t o_oc, o_oc_next;
  vc_t      o_p, o_p_next;

  assign en_p[6]       = !pv[6] || out_ch.ready;
  assign en_p[5]       = !pv[5] || en_p[6];
  assign en_p[4]       = !pv[4] || en_p[5];
  assign en_p[3]       = !pv[3] || en_p[4];
  assign en_p[2]       = !pv[2] || en_p[3];
  assign en_p[1]       = !pv[1] || en_p[2];
  assign div_out_ready = en_p[1];

  assign dsd  = side_t'(div_side);
  // a quotient that does not fit the distance saturates to all ones
  assign qx    = QX'(div_quo);
  assign ratio = (|(qx >> DIST_W)) ? '1 : qx[DIST_W-1:0];

  // stage 1: v times the low and high halves of the distance
  always_comb begin
    t1_next.sd = dsd;
    for (int k = 0; k < 3; k++) begin
      t1_next.pl[k] = LW'($signed(dsd.v[k])) *
                      LW'($signed({1'b0, ratio[DIST_HALF-1:0]}));
      t1_next.ph[k] = LW'($signed(dsd.v[k])) *
                      LW'($signed({1'b0, ratio[DIST_W-1:DIST_HALF]}));
    end
  end

  // stage 2: hit point, floor shift, add start, saturate
  always_comb begin
    logic signed [PW-1:0] full;
    logic signed [PW-1:0] sh;
    logic signed [SW-1:0] sum;
    full = '0;
    sh   = '0;
    sum  = '0;
    t2_next.sd = t1.sd;
    for (int k = 0; k < 3; k++) begin
      full = (PW'($signed(t1.ph[k])) <<< DIST_HALF) + PW'($signed(t1.pl[k]));
      sh   = full >>> RATIO_FRAC_BITS;
      sum  = SW'(sh) + SW'($signed(t1.sd.s[k]));
      priority if (sum > SW'(CMAXV)) begin
        t2_next.p[k] = CW'(CMAXV);
      end else if (sum < SW'(CMINV)) begin
        t2_next.p[k] = CW'(CMINV);
      end else begin
        t2_next.p[k] = sum[CW-1:0];
      end
    end
  end

  // stage 3: cross product terms of each edge with the point
  always_comb begin
    vd_t e [3];
    vd_t f [3];
    t3_next.sd = t2.sd;
    t3_next.p  = t2.p;
    for (int k = 0; k < 3; k++) begin
      e[0][k] = t2.sd.u[k];
      e[1][k] = t2.sd.w[k];
      e[2][k] = cdiff(t2.sd.a[k], t2.sd.c[k]);
      f[0][k] = cdiff(t2.p[k], t2.sd.a[k]);
      f[1][k] = cdiff(t2.p[k], t2.sd.b[k]);
      f[2][k] = cdiff(t2.p[k], t2.sd.c[k]);
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        t3_next.ep[j][k][0] = smul(e[j][(k+1)%3], f[j][(k+2)%3]);
        t3_next.ep[j][k][1] = smul(f[j][(k+1)%3], e[j][(k+2)%3]);
      end
    end
  end

  // stage 4: edge normals
  always_comb begin
    t4_next.oc = t3.sd.oc;
    t4_next.p  = t3.p;
    t4_next.n  = t3.sd.n;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        t4_next.t[j][k] = NW'($signed(t3.ep[j][k][0])) - NW'($signed(t3.ep[j][k][1]));
      end
    end
  end

  // stage 5: edge normal times triangle normal, split in two products
  always_comb begin
    t5_next.oc = t4.oc;
    t5_next.p  = t4.p;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        t5_next.ml[j][k] = ML'($signed(t4.t[j][k])) *
                           ML'($signed({1'b0, t4.n[k][NLO-1:0]}));
        t5_next.mh[j][k] = MH'($signed(t4.t[j][k])) *
                           MH'($signed(t4.n[k][NW-1:NLO]));
      end
    end
  end

  // stage 6 (output register): edge signs and final outcome
  always_comb begin
    logic signed [EW-1:0] acc;
    logic                 in_all;
    in_all = 1'b1;
    acc    = '0;
    for (int j = 0; j < 3; j++) begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        acc = acc + (EW'($signed(t5.mh[j][k])) <<< NLO) + EW'($signed(t5.ml[j][k]));
      end
      in_all = in_all && !acc[EW-1];
    end
    if (t5.oc == OC_HIT) begin
      o_oc_next = in_all ? OC_HIT : OC_OUTSIDE;
      o_p_next  = t5.p;
    end else begin
      // early rejects carry no point
      o_oc_next = t5.oc;
      o_p_next  = '0;
    end
    o_hit_next = (o_oc_next == OC_HIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      if (en_p[1]) pv[1] <= div_out_valid;
      if (en_p[2]) pv[2] <= pv[1];
      if (en_p[3]) pv[3] <= pv[2];
      if (en_p[4]) pv[4] <= pv[3];
      if (en_p[5]) pv[5] <= pv[4];
      if (en_p[6]) pv[6] <= pv[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en_p[1]) t1 <= t1_next;
    if (en_p[2]) t2 <= t2_next;
    if (en_p[3]) t3 <= t3_next;
    if (en_p[4]) t4 <= t4_next;
    if (en_p[5]) t5 <= t5_next;
    if (en_p[6]) begin
      o_hit <= o_hit_next;
      o_oc  <= o_oc_next;
      o_p   <= o_p_next;
    end
  end

  assign out_ch.valid   = pv[6];
  assign out_ch.hit     = o_hit;
  assign out_ch.outcome = o_oc;
  assign out_ch.point_x = o_p[0];
  assign out_ch.point_y = o_p[1];
  assign out_ch.point_z = o_p[2];

`ifndef SYNTHESIS
  a_hit_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.hit == (out_ch.outcome == OC_HIT)))
    else $error("hit flag disagrees with outcome");

  a_reject_point: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.outcome == OC_DEGEN || out_ch.outcome == OC_NOT_FACING ||
                     out_ch.outcome == OC_BEHIND)
    |-> (out_ch.point_x == '0 && out_ch.point_y == '0 && out_ch.point_z == '0))
    else $error("early reject carries a point");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    qv[5] && s5.sd.oc == OC_HIT |-> s5.den != '0 && !s5.den[DPW-1] && !s5.num[DPW-1])
    else $error("divider operands out of range for an open item");
`endif

endmodule
